// ===== src/fts_pkg.sv =====
// Package for the filename timestamp scanner: types, constants and the month length table.
package fts_pkg;

   localparam logic [11:0] YEAR_LOW_RESET  = 12'd2000;
   localparam logic [11:0] YEAR_HIGH_RESET = 12'd2999;
   localparam logic [3:0]  RUN_FULL        = 4'd14;
   localparam logic [3:0]  RUN_DATE        = 4'd8;
   localparam logic [3:0]  RUN_MAX         = 4'd15;
   localparam logic [4:0]  NOON_HOUR       = 5'd12;
   localparam int          WINDOW_WIDTH    = 56;

   typedef enum logic {
      REG_YEAR_LOW  = 1'b0,
      REG_YEAR_HIGH = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic        date_only;
   } stamp_type;

   function automatic logic [4:0] fts_month_days(input logic [3:0] month, input logic leap);
      logic [4:0] days;
      case (month)
         4'd2: begin
            days = leap ? 5'd29 : 5'd28;
         end
         4'd4, 4'd6, 4'd9, 4'd11: begin
            days = 5'd30;
         end
         default: begin
            days = 5'd31;
         end
      endcase
      return days;
   endfunction

   function automatic logic [6:0] fts_bcd2(input logic [7:0] bcd);
      return 7'({3'b0, bcd[7:4]} * 7'd10 + {3'b0, bcd[3:0]});
   endfunction

endpackage

// ===== src/filename_timestamp_scanner.sv =====
// Top level of the filename timestamp scanner: digit run tracking, date check, result register.
// Latency: a name's result word is valid in the cycle after its last character is accepted.
// Throughput: one character word per cycle while req_ready is high; the run tracker and date check are combinational.
// The input stalls only while a result word waits and rsp_ready is low.
// Reset (synchronous, active high) clears the run state, the kept match and the result
// valid flag, and sets year_low to 2000 and year_high to 2999.
module filename_timestamp_scanner (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic        req_is_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_found,
   output logic [11:0] rsp_year,
   output logic [3:0]  rsp_month,
   output logic [4:0]  rsp_day,
   output logic [4:0]  rsp_hour,
   output logic [5:0]  rsp_minute,
   output logic [5:0]  rsp_second,
   output logic        rsp_date_only,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import fts_pkg::*;

   logic [11:0]             year_low_ff, year_high_ff;
   logic [WINDOW_WIDTH-1:0] window_ff, window_in;
   logic [3:0]              run_len_ff, run_len_in;
   logic                    match_ff, match_in;
   stamp_type               kept_ff, kept_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_found_ff, rsp_found_in;
   stamp_type               rsp_ff, rsp_in;

   logic                    accept, is_digit, cfg_write;
   reg_index_type           cfg_index;
   logic [WINDOW_WIDTH-1:0] shifted, cand_win;
   logic [3:0]              cand_len;
   logic                    len14, len8, capture, leap, year_ok, date_ok, time_ok;
   logic [15:0]             year_bcd;
   logic [7:0]              month_bcd, day_bcd;
   logic [13:0]             year_bin;
   logic [6:0]              month_bin, day_bin, hour_bin, minute_bin, second_bin;
   logic                    lo_zero, lo_div4, hi_div4;
   logic [1:0]              lo_sum, hi_sum;
   stamp_type               cand;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;
   assign cfg_index = reg_index_type'(paddr[2]);
   assign prdata    = (cfg_index == REG_YEAR_HIGH) ? {20'b0, year_high_ff} : {20'b0, year_low_ff};

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_digit  = (req_char_code >= 8'd48) && (req_char_code <= 8'd57);
   assign shifted   = {window_ff[WINDOW_WIDTH-5:0], req_char_code[3:0]};

   // a digit on the last character is checked with itself taken in
   always_comb begin
      cand_win = is_digit ? shifted : window_ff;
      if (is_digit) begin
         cand_len = (run_len_ff == RUN_MAX) ? RUN_MAX : run_len_ff + 4'd1;
      end else begin
         cand_len = run_len_ff;
      end
      len14 = (cand_len == RUN_FULL);
      len8  = (cand_len == RUN_DATE);

      year_bcd  = len14 ? cand_win[55:40] : cand_win[31:16];
      month_bcd = len14 ? cand_win[39:32] : cand_win[15:8];
      day_bcd   = len14 ? cand_win[31:24] : cand_win[7:0];
      hour_bin   = fts_bcd2(cand_win[23:16]);
      minute_bin = fts_bcd2(cand_win[15:8]);
      second_bin = fts_bcd2(cand_win[7:0]);
      month_bin  = fts_bcd2(month_bcd);
      day_bin    = fts_bcd2(day_bcd);
      year_bin   = 14'({7'b0, fts_bcd2(year_bcd[15:8])} * 14'd100
                       + {7'b0, fts_bcd2(year_bcd[7:0])});

      // leap years straight from the BCD digits
      lo_zero = (year_bcd[7:0] == 8'h00);
      lo_sum  = {year_bcd[4], 1'b0} + year_bcd[1:0];
      hi_sum  = {year_bcd[12], 1'b0} + year_bcd[9:8];
      lo_div4 = (lo_sum == 2'd0);
      hi_div4 = (hi_sum == 2'd0);
      leap    = (lo_div4 && !lo_zero) || (lo_zero && hi_div4);

      year_ok = (year_bin >= {2'b0, year_low_ff}) && (year_bin <= {2'b0, year_high_ff})
                && (year_bin != 14'd0);
      date_ok = (month_bin >= 7'd1) && (month_bin <= 7'd12) && (day_bin >= 7'd1)
                && (day_bin <= {2'b0, fts_month_days(month_bin[3:0], leap)});
      time_ok = !len14 || ((hour_bin <= 7'd23) && (minute_bin <= 7'd59)
                && (second_bin <= 7'd59));
      capture = accept && (!is_digit || req_is_last) && !match_ff && (len14 || len8)
                && year_ok && date_ok && time_ok;

      cand.year      = year_bin[11:0];
      cand.month     = month_bin[3:0];
      cand.day       = day_bin[4:0];
      cand.hour      = len14 ? hour_bin[4:0] : NOON_HOUR;
      cand.minute    = len14 ? minute_bin[5:0] : 6'd0;
      cand.second    = len14 ? second_bin[5:0] : 6'd0;
      cand.date_only = len8;
   end

   always_comb begin
      window_in    = window_ff;
      run_len_in   = run_len_ff;
      match_in     = match_ff || capture;
      kept_in      = capture ? cand : kept_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_found_in = rsp_found_ff;
      rsp_in       = rsp_ff;
      if (accept) begin
         if (is_digit) begin
            window_in  = shifted;
            run_len_in = cand_len;
         end else begin
            window_in  = '0;
            run_len_in = '0;
         end
         if (req_is_last) begin
            rsp_valid_in = 1'b1;
            rsp_found_in = match_in;
            rsp_in       = kept_in;
            window_in    = '0;
            run_len_in   = '0;
            match_in     = 1'b0;
            kept_in      = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         year_low_ff  <= YEAR_LOW_RESET;
         year_high_ff <= YEAR_HIGH_RESET;
         window_ff    <= '0;
         run_len_ff   <= '0;
         match_ff     <= 1'b0;
         kept_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cfg_write && cfg_index == REG_YEAR_LOW) begin
            year_low_ff <= pwdata[11:0];
         end
         if (cfg_write && cfg_index == REG_YEAR_HIGH) begin
            year_high_ff <= pwdata[11:0];
         end
         window_ff    <= window_in;
         run_len_ff   <= run_len_in;
         match_ff     <= match_in;
         kept_ff      <= kept_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff <= rsp_found_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_year      = rsp_ff.year;
   assign rsp_month     = rsp_ff.month;
   assign rsp_day       = rsp_ff.day;
   assign rsp_hour      = rsp_ff.hour;
   assign rsp_minute    = rsp_ff.minute;
   assign rsp_second    = rsp_ff.second;
   assign rsp_date_only = rsp_ff.date_only;

`ifndef NO_ASSERTIONS
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(accept && req_is_last))
      else $error("result word without a last character");
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> (rsp_ff == '0))
      else $error("no match but fields not zero");
   a_date_noon: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.date_only) |->
      (rsp_found_ff && rsp_ff.hour == NOON_HOUR && rsp_ff.minute == 6'd0
       && rsp_ff.second == 6'd0))
      else $error("date-only match without noon time");
   a_clear_on_last: assert property (@(posedge clock) disable iff (reset)
      (accept && req_is_last) |=> (run_len_ff == 4'd0 && !match_ff && window_ff == '0))
      else $error("state not cleared after last character");
`endif

endmodule

// ===== tb/fts_checker.sv =====
// Checker for the filename timestamp scanner: tracks each name, predicts its result word and compares.
module fts_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic        req_is_last,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_found,
   input  logic [11:0] rsp_year,
   input  logic [3:0]  rsp_month,
   input  logic [4:0]  rsp_day,
   input  logic [4:0]  rsp_hour,
   input  logic [5:0]  rsp_minute,
   input  logic [5:0]  rsp_second,
   input  logic        rsp_date_only,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          mismatches,
   output int          outstanding,
   output int          words_checked,
   output int          words_with_stamp
);
   timeunit 1ns;
   timeprecision 1ps;

   import fts_pkg::*;

   localparam logic [7:0] CHAR_ZERO = 8'd48;
   localparam logic [7:0] CHAR_NINE = 8'd57;

   typedef struct packed {
      logic      found;
      stamp_type stamp;
   } scan_word_type;

   logic [11:0]   year_lo;
   logic [11:0]   year_hi;
   logic [55:0]   digit_window;
   logic [3:0]    run_len;
   logic          kept_valid;
   stamp_type     kept;
   scan_word_type words_due[$];

   task automatic report(input string what);
      $display("[%0t] scanner mismatch: %s", $time, what);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report($sformatf("%s is %0d, expected %0d", name, got, want));
      end
   endtask

   function automatic int run_digits(input int first, input int count);
      int v;
      v = 0;
      for (int i = first; i < first + count; i++) begin
         v = v * 10 + int'(digit_window[4 * (int'(run_len) - 1 - i) +: 4]);
      end
      return v;
   endfunction

   function automatic int days_in(input int y, input int m);
      bit leap;
      leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      case (m)
         2: begin
            return leap ? 29 : 28;
         end
         4, 6, 9, 11: begin
            return 30;
         end
         default: begin
            return 31;
         end
      endcase
   endfunction

   // first accepted run of the name is kept, later runs are ignored
   function automatic void keep_run();
      int len, y, mo, d, h, mi, s;
      len = int'(run_len);
      if (kept_valid || (len != int'(RUN_FULL) && len != int'(RUN_DATE))) return;
      y = run_digits(0, 4);
      if (y < int'(year_lo) || y > int'(year_hi) || y == 0) return;
      mo = run_digits(4, 2);
      d = run_digits(6, 2);
      if (mo < 1 || mo > 12 || d < 1 || d > days_in(y, mo)) return;
      h = int'(NOON_HOUR);
      mi = 0;
      s = 0;
      if (len == int'(RUN_FULL)) begin
         h = run_digits(8, 2);
         mi = run_digits(10, 2);
         s = run_digits(12, 2);
         if (h > 23 || mi > 59 || s > 59) return;
      end
      kept_valid = 1'b1;
      kept.year = 12'(y);
      kept.month = 4'(mo);
      kept.day = 5'(d);
      kept.hour = 5'(h);
      kept.minute = 6'(mi);
      kept.second = 6'(s);
      kept.date_only = (len == int'(RUN_DATE));
   endfunction

   function automatic void clear_scan();
      digit_window = '0;
      run_len = '0;
      kept_valid = 1'b0;
      kept = '0;
   endfunction

   function automatic void take_char(input logic [7:0] code, input logic is_end);
      scan_word_type w;
      if (code >= CHAR_ZERO && code <= CHAR_NINE) begin
         digit_window = {digit_window[51:0], 4'(code - CHAR_ZERO)};
         if (run_len < RUN_MAX) run_len++;
         if (is_end) keep_run();
      end else begin
         keep_run();
         run_len = '0;
         digit_window = '0;
      end
      if (is_end) begin
         w.found = kept_valid;
         w.stamp = kept;
         words_due.push_back(w);
         clear_scan();
      end
   endfunction

   always @(posedge clock) begin
      scan_word_type want;
      if (reset) begin
         clear_scan();
         year_lo = YEAR_LOW_RESET;
         year_hi = YEAR_HIGH_RESET;
         words_due.delete();
         outstanding <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (words_due.size() == 0) begin
               report($sformatf("unexpected result word, found = %0b", rsp_found));
            end else begin
               want = words_due.pop_front();
               check_field("found", 32'(rsp_found), 32'(want.found));
               check_field("year", 32'(rsp_year), 32'(want.stamp.year));
               check_field("month", 32'(rsp_month), 32'(want.stamp.month));
               check_field("day", 32'(rsp_day), 32'(want.stamp.day));
               check_field("hour", 32'(rsp_hour), 32'(want.stamp.hour));
               check_field("minute", 32'(rsp_minute), 32'(want.stamp.minute));
               check_field("second", 32'(rsp_second), 32'(want.stamp.second));
               check_field("date_only", 32'(rsp_date_only), 32'(want.stamp.date_only));
               words_checked++;
               if (want.found) words_with_stamp++;
            end
         end
         if (req_valid && req_ready) take_char(req_char_code, req_is_last);
         if (psel && penable && pwrite && pready) begin
            case (reg_index_type'(paddr[2]))
               REG_YEAR_LOW: begin
                  year_lo = pwdata[11:0];
               end
               REG_YEAR_HIGH: begin
                  year_hi = pwdata[11:0];
               end
               default: begin
               end
            endcase
         end
         outstanding <= words_due.size();
      end
   end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the filename timestamp scanner: clock, reset, name stimulus and verdict.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import fts_pkg::*;

   localparam int RANDOM_CHARS = 1400;
   localparam int PHASES = 7;
   localparam logic [7:0] CHAR_ZERO = 8'd48;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_code = '0;
   logic        req_is_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_found;
   logic [11:0] rsp_year;
   logic [3:0]  rsp_month;
   logic [4:0]  rsp_day;
   logic [4:0]  rsp_hour;
   logic [5:0]  rsp_minute;
   logic [5:0]  rsp_second;
   logic        rsp_date_only;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   int mismatches;
   int outstanding;
   int words_checked;
   int words_with_stamp;

   bit   idle_on = 1'b1;
   int   stall_left = 0;
   int   chars_sent = 0;
   int   names_sent = 0;
   int   year_lo_now = int'(YEAR_LOW_RESET);
   int   year_hi_now = int'(YEAR_HIGH_RESET);
   logic [7:0] name_buf[$];

   int phase_lo[PHASES] = '{0, 1970, 0, 3000, 4095, 2038, 1900};
   int phase_hi[PHASES] = '{0, 2099, 4095, 2000, 4095, 2038, 2999};

   string directed_names[20] = '{
      "IMG_20240229_123456.jpg", "20231231235959", "a21000229b20250101c20260101",
      "x20230229.png", "20000229", "19991231", "30000101_000000", "29991231",
      "202401011200001", "20240101240000_", "20240101236000", "20240101235960",
      "20240001", "20241301-20240100", "20240431", "20240132", "/20240615:",
      "21000229", "7", "."
   };

   filename_timestamp_scanner DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_char_code(req_char_code), .req_is_last(req_is_last),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_found(rsp_found), .rsp_year(rsp_year), .rsp_month(rsp_month),
      .rsp_day(rsp_day), .rsp_hour(rsp_hour), .rsp_minute(rsp_minute),
      .rsp_second(rsp_second), .rsp_date_only(rsp_date_only),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   fts_checker scan_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_char_code(req_char_code), .req_is_last(req_is_last),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_found(rsp_found), .rsp_year(rsp_year), .rsp_month(rsp_month),
      .rsp_day(rsp_day), .rsp_hour(rsp_hour), .rsp_minute(rsp_minute),
      .rsp_second(rsp_second), .rsp_date_only(rsp_date_only),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready),
      .mismatches(mismatches), .outstanding(outstanding),
      .words_checked(words_checked), .words_with_stamp(words_with_stamp)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("tb_top NOT OK");
      $finish;
   end

   // result side back-pressure: rsp_ready is dropped in bursts that start only while idle_on is set
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (idle_on && !reset && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 16);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_char(input logic [7:0] code, input logic is_end);
      int gap;
      gap = 0;
      if (idle_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 17);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_char_code <= code;
      req_is_last <= is_end;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      chars_sent++;
      if (is_end) names_sent++;
   endtask

   task automatic send_buf();
      for (int i = 0; i < name_buf.size(); i++) begin
         send_char(name_buf[i], i == name_buf.size() - 1);
      end
   endtask

   task automatic send_text(input string s);
      name_buf.delete();
      for (int i = 0; i < s.len(); i++) name_buf.push_back(s[i]);
      send_buf();
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic apb_write(input reg_index_type idx, input logic [11:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= {20'($urandom), value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_years(input int lo, input int hi);
      drain();
      apb_write(REG_YEAR_LOW, 12'(lo));
      apb_write(REG_YEAR_HIGH, 12'(hi));
      year_lo_now = lo;
      year_hi_now = hi;
   endtask

   function automatic void push_digits(input int value, input int ndig);
      int div;
      div = 1;
      repeat (ndig - 1) div *= 10;
      repeat (ndig) begin
         name_buf.push_back(CHAR_ZERO + 8'((value / div) % 10));
         div /= 10;
      end
   endfunction

   function automatic void push_random_digits(input int n);
      repeat (n) name_buf.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
   endfunction

   function automatic void push_filler(input int n);
      logic [7:0] c;
      repeat (n) begin
         do c = 8'($urandom_range(32, 126));
         while (c >= CHAR_ZERO && c <= CHAR_ZERO + 8'd9);
         name_buf.push_back(c);
      end
   endfunction

   // mostly plausible dates, with a share of bad months, days and times
   function automatic void push_stamp(input bit full);
      int y, mo, d, r;
      y = ($urandom_range(0, 4) != 0) ? $urandom_range(year_lo_now, year_hi_now)
                                      : $urandom_range(0, 9999);
      if (y > 9999) y = 9999;
      mo = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 12)
                                       : ($urandom_range(0, 1) ? 0 : $urandom_range(13, 99));
      r = $urandom_range(0, 19);
      if (r < 13) d = $urandom_range(1, 28);
      else if (r < 19) d = $urandom_range(28, 31);
      else d = $urandom_range(0, 1) ? 0 : $urandom_range(32, 99);
      push_digits(y, 4);
      push_digits(mo, 2);
      push_digits(d, 2);
      if (full) begin
         push_digits(($urandom_range(0, 11) != 0) ? $urandom_range(0, 23)
                                                  : $urandom_range(24, 99), 2);
         push_digits(($urandom_range(0, 11) != 0) ? $urandom_range(0, 59)
                                                  : $urandom_range(60, 99), 2);
         push_digits(($urandom_range(0, 11) != 0) ? $urandom_range(0, 59)
                                                  : $urandom_range(60, 99), 2);
      end
   endfunction

   function automatic void make_random_name();
      int kind;
      name_buf.delete();
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
         push_filler($urandom_range(0, 6));
         push_stamp(1'($urandom_range(0, 1)));
         if ($urandom_range(0, 2) == 0) begin
            push_filler($urandom_range(1, 3));
            push_stamp(1'($urandom_range(0, 1)));
         end
         if ($urandom_range(0, 2) != 0) push_filler($urandom_range(1, 5));
      end else if (kind == 7) begin
         repeat ($urandom_range(1, 24)) begin
            if ($urandom_range(0, 1)) name_buf.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
            else name_buf.push_back(8'($urandom_range(0, 255)));
         end
      end else if (kind == 8) begin
         push_filler($urandom_range(0, 3));
         case ($urandom_range(0, 4))
            0: push_random_digits(7);
            1: push_random_digits(9);
            2: push_random_digits(13);
            3: push_random_digits(15);
            default: push_random_digits($urandom_range(16, 24));
         endcase
         push_filler($urandom_range(0, 2));
      end else begin
         push_random_digits($urandom_range(1, 20));
      end
      if (name_buf.size() == 0) push_filler(1);
   endfunction

   initial begin
      int phase_end;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_names[i]) send_text(directed_names[i]);
      // non-ASCII separators around a full stamp, name ends on a control code
      name_buf.delete();
      name_buf.push_back(8'hFF);
      push_digits(20250615, 8);
      push_digits(123000, 6);
      name_buf.push_back(8'h80);
      name_buf.push_back(8'h00);
      send_buf();

      for (int p = 0; p < PHASES; p++) begin
         set_years(phase_lo[p], phase_hi[p]);
         idle_on = (p != 2) && (p != PHASES - 1);
         if (phase_lo[p] == 0 && phase_hi[p] == 4095) begin
            send_text("00000101");
            send_text("y00001231235959");
            send_text("40950228");
         end
         phase_end = chars_sent + RANDOM_CHARS / PHASES;
         while (chars_sent < phase_end) begin
            make_random_name();
            send_buf();
         end
      end

      drain();
      repeat (4) @(posedge clock);
      $display("Sent %0d characters in %0d names; %0d result words checked, %0d with a stamp.",
               chars_sent, names_sent, words_checked, words_with_stamp);
      $display("Year windows: reset values and %0d written ranges, empty and full span included.",
               PHASES);
      if (mismatches == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
